### rtl/rpva_pkg.sv
`default_nettype none

package rpva_pkg;

  // Vertex index within one pentagon
  localparam int unsigned IDX_W = 3;
  typedef logic [IDX_W-1:0] vidx_t;

  localparam vidx_t FIRST_IDX = 3'd0;
  localparam vidx_t LAST_IDX  = 3'd4;

  // Rotation coefficients are signed Q1.30
  localparam int unsigned COEF_W      = 32;
  localparam int unsigned ROUND_SHIFT = 30;

  // Area: half of the shoelace sum, fraction cut from 32 to 16 bits
  localparam int unsigned AREA_SHIFT = 17;
  localparam int unsigned AREA_W     = 63;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned FRAC_W     = 16;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // Control that travels with each vertex beat
  typedef struct packed {
    logic  valid;
    vidx_t idx;
  } beat_t;

  // cos(72k degrees), rounded to nearest
  function automatic logic signed [COEF_W-1:0] cos_coef(vidx_t k);
    logic signed [COEF_W-1:0] c;
    case (k)
      3'd0:    c = 32'sd1073741824;
      3'd1:    c = 32'sd331804471;
      3'd2:    c = -32'sd868675383;
      3'd3:    c = -32'sd868675383;
      3'd4:    c = 32'sd331804471;
      default: c = '0;
    endcase
    return c;
  endfunction

  // sin(72k degrees), rounded to nearest
  function automatic logic signed [COEF_W-1:0] sin_coef(vidx_t k);
    logic signed [COEF_W-1:0] s;
    case (k)
      3'd0:    s = '0;
      3'd1:    s = 32'sd1021189159;
      3'd2:    s = 32'sd631129609;
      3'd3:    s = -32'sd631129609;
      3'd4:    s = -32'sd1021189159;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/rpva_issue.sv
`default_nettype none

// Holds one input pentagon and issues its five vertex beats in order.
module rpva_issue #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           en_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_y_i,
  output rpva_pkg::beat_t               beat_o,
  output logic signed [COORD_WIDTH-1:0] vx_o,
  output logic signed [COORD_WIDTH-1:0] vy_o,
  output logic signed [COORD_WIDTH-1:0] cx_o,
  output logic signed [COORD_WIDTH-1:0] cy_o
);

  logic                 busy_q, busy_d;
  rpva_pkg::vidx_t      idx_q, idx_d;
  logic                 accept;
  logic                 issue_last;
  logic signed [COORD_WIDTH-1:0] vx_q, vy_q, cx_q, cy_q;

  // Next item may load while the last vertex of the current one issues
  assign issue_last = en_i && busy_q && (idx_q == rpva_pkg::LAST_IDX);
  assign in_ready_o = !busy_q || issue_last;
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (accept) begin
      busy_d = 1'b1;
      idx_d  = rpva_pkg::FIRST_IDX;
    end else if (issue_last) begin
      busy_d = 1'b0;
    end else if (en_i && busy_q) begin
      idx_d = idx_q + rpva_pkg::vidx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= rpva_pkg::FIRST_IDX;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Held pentagon
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q <= vertex_x_i;
      vy_q <= vertex_y_i;
      cx_q <= center_x_i;
      cy_q <= center_y_i;
    end
  end

  assign beat_o.valid = busy_q;
  assign beat_o.idx   = idx_q;
  assign vx_o = vx_q;
  assign vy_o = vy_q;
  assign cx_o = cx_q;
  assign cy_o = cy_q;

endmodule

`default_nettype wire

### rtl/rpva_rotate.sv
`default_nettype none

// Four stages: offset, coefficient products, rounded sums, center add and clamp.
module rpva_rotate #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           en_i,
  input  rpva_pkg::beat_t               beat_i,
  input  wire logic signed [COORD_WIDTH-1:0] vx_i,
  input  wire logic signed [COORD_WIDTH-1:0] vy_i,
  input  wire logic signed [COORD_WIDTH-1:0] cx_i,
  input  wire logic signed [COORD_WIDTH-1:0] cy_i,
  output rpva_pkg::beat_t               beat_o,
  output logic signed [COORD_WIDTH-1:0] x_o,
  output logic signed [COORD_WIDTH-1:0] y_o,
  output logic                          sat_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = DW + rpva_pkg::COEF_W;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned RW = SW - rpva_pkg::ROUND_SHIFT;
  localparam int unsigned XW = RW + 1;

  localparam logic signed [SW-1:0] RND_HALF =
    {{(SW - rpva_pkg::ROUND_SHIFT){1'b0}}, 1'b1, {(rpva_pkg::ROUND_SHIFT - 1){1'b0}}};
  localparam logic signed [XW-1:0] CMAX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [XW-1:0] CMIN = ~CMAX;

  rpva_pkg::beat_t s1_q, s2_q, s3_q, s4_q;

  logic signed [DW-1:0] dx1_q, dy1_q;
  logic signed [W-1:0]  cx1_q, cy1_q, cx2_q, cy2_q, cx3_q, cy3_q;
  logic signed [rpva_pkg::COEF_W-1:0] cos_c, sin_c;
  logic signed [PW-1:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [RW-1:0] rx_q, ry_q;
  logic signed [XW-1:0] ax, ay;
  logic signed [W-1:0]  x_d, y_d, x_q, y_q;
  logic                 sat_d, sat_q;

  // Control pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else if (en_i) begin
      s1_q <= beat_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
    end
  end

  assign cos_c = rpva_pkg::cos_coef(s1_q.idx);
  assign sin_c = rpva_pkg::sin_coef(s1_q.idx);

  // Round: add half, floor by 2^30
  assign sum_x = SW'(pxc_q) + SW'(pys_q) + RND_HALF;
  assign sum_y = SW'(pyc_q) - SW'(pxs_q) + RND_HALF;

  // Add center and clamp to the coordinate range
  always_comb begin
    ax    = XW'(cx3_q) + XW'(rx_q);
    ay    = XW'(cy3_q) + XW'(ry_q);
    sat_d = 1'b0;
    x_d   = ax[W-1:0];
    y_d   = ay[W-1:0];
    if (ax > CMAX) begin
      x_d   = CMAX[W-1:0];
      sat_d = 1'b1;
    end else if (ax < CMIN) begin
      x_d   = CMIN[W-1:0];
      sat_d = 1'b1;
    end
    if (ay > CMAX) begin
      y_d   = CMAX[W-1:0];
      sat_d = 1'b1;
    end else if (ay < CMIN) begin
      y_d   = CMIN[W-1:0];
      sat_d = 1'b1;
    end
  end

  // Data pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q <= DW'(vx_i) - DW'(cx_i);
      dy1_q <= DW'(vy_i) - DW'(cy_i);
      cx1_q <= cx_i;
      cy1_q <= cy_i;

      pxc_q <= PW'(dx1_q) * PW'(cos_c);
      pys_q <= PW'(dy1_q) * PW'(sin_c);
      pyc_q <= PW'(dy1_q) * PW'(cos_c);
      pxs_q <= PW'(dx1_q) * PW'(sin_c);
      cx2_q <= cx1_q;
      cy2_q <= cy1_q;

      rx_q  <= sum_x[SW-1:rpva_pkg::ROUND_SHIFT];
      ry_q  <= sum_y[SW-1:rpva_pkg::ROUND_SHIFT];
      cx3_q <= cx2_q;
      cy3_q <= cy2_q;

      x_q   <= x_d;
      y_q   <= y_d;
      sat_q <= sat_d;
    end
  end

  assign beat_o = s4_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign sat_o  = sat_q;

endmodule

`default_nettype wire

### rtl/rpva_area.sv
`default_nettype none

// Shoelace area over the vertex stream: cross products, term, running sum, magnitude.
module rpva_area #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           en_i,
  input  rpva_pkg::beat_t               beat_i,
  input  wire logic signed [COORD_WIDTH-1:0] x_i,
  input  wire logic signed [COORD_WIDTH-1:0] y_i,
  input  wire                           sat_i,
  output rpva_pkg::beat_t               beat_o,
  output logic signed [COORD_WIDTH-1:0] x_o,
  output logic signed [COORD_WIDTH-1:0] y_o,
  output logic                          sat_o,
  output logic                          any_o,
  output logic [2*COORD_WIDTH+4-rpva_pkg::AREA_SHIFT-1:0] mag_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned AP    = 2 * W;
  localparam int unsigned TW    = AP + 2;
  localparam int unsigned ACC_W = AP + 4;
  localparam int unsigned MAG_W = ACC_W - rpva_pkg::AREA_SHIFT;

  rpva_pkg::beat_t s5_q, s6_q, s7_q, s8_q;

  logic signed [W-1:0]  prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic signed [AP-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [W-1:0]  x5_q, y5_q, x6_q, y6_q, x7_q, y7_q, x8_q, y8_q;
  logic                 sat5_q, sat6_q, sat7_q, sat8_q;
  logic signed [TW-1:0] term_d, term_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic                 any_d, any7_q, any8_q;
  logic [ACC_W-1:0]     mag_full;
  logic [MAG_W-1:0]     mag_q;

  // Control pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
      s6_q <= '0;
      s7_q <= '0;
      s8_q <= '0;
    end else if (en_i) begin
      s5_q <= beat_i;
      s6_q <= s5_q;
      s7_q <= s6_q;
      s8_q <= s7_q;
    end
  end

  // Previous and first vertex of the current pentagon
  always_ff @(posedge clk_i) begin
    if (en_i && beat_i.valid) begin
      prev_x_q <= x_i;
      prev_y_q <= y_i;
      if (beat_i.idx == rpva_pkg::FIRST_IDX) begin
        first_x_q <= x_i;
        first_y_q <= y_i;
      end
    end
  end

  // Edge term; the last vertex also closes the ring back to the first
  always_comb begin
    term_d = TW'(pa_q) - TW'(pb_q);
    if (s5_q.idx == rpva_pkg::LAST_IDX) begin
      term_d = term_d + TW'(pc_q) - TW'(pd_q);
    end
    if (s5_q.idx == rpva_pkg::FIRST_IDX) begin
      term_d = '0;
    end
  end

  // Running sum restarts on the first vertex
  always_comb begin
    if (s6_q.idx == rpva_pkg::FIRST_IDX) begin
      acc_d = ACC_W'(term_q);
      any_d = sat6_q;
    end else begin
      acc_d = acc_q + ACC_W'(term_q);
      any_d = any7_q || sat6_q;
    end
  end

  assign mag_full = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  // Data pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= AP'(prev_x_q) * AP'(y_i);
      pb_q   <= AP'(x_i) * AP'(prev_y_q);
      pc_q   <= AP'(x_i) * AP'(first_y_q);
      pd_q   <= AP'(first_x_q) * AP'(y_i);
      x5_q   <= x_i;
      y5_q   <= y_i;
      sat5_q <= sat_i;

      term_q <= term_d;
      x6_q   <= x5_q;
      y6_q   <= y5_q;
      sat6_q <= sat5_q;

      mag_q  <= mag_full[ACC_W-1:rpva_pkg::AREA_SHIFT];
      any8_q <= any7_q;
      x8_q   <= x7_q;
      y8_q   <= y7_q;
      sat8_q <= sat7_q;
    end
  end

  // Accumulator stage keeps the last valid beat as running state
  always_ff @(posedge clk_i) begin
    if (en_i && s6_q.valid) begin
      acc_q  <= acc_d;
      any7_q <= any_d;
      x7_q   <= x6_q;
      y7_q   <= y6_q;
      sat7_q <= sat6_q;
    end
  end

  assign beat_o = s8_q;
  assign x_o    = x8_q;
  assign y_o    = y8_q;
  assign sat_o  = sat8_q;
  assign any_o  = any8_q;
  assign mag_o  = mag_q;

endmodule

`default_nettype wire

### rtl/regular_pentagon_vertices_area_core.sv
// Each vertex beat passes the issue sequencer, rotate pipe, area pipe and output register.
// Throughput: one vertex result per cycle unless the result channel stalls; the five-beat
// issue sequencer and the single result channel set it; the next pentagon loads as the last vertex issues.
// Stalls on the result channel freeze the whole 9-stage pipe; nothing is lost.
// Reset (rst_ni low, asynchronous) clears all valid bits, the sequencer and area_limit.
`default_nettype none

module regular_pentagon_vertices_area_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_y_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [rpva_pkg::IDX_W-1:0]         vertex_index_o,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic                               is_last_o,
  output logic [rpva_pkg::AREA_W-1:0]        poly_area_o,
  output logic                               below_limit_o,
  output logic                               overflow_o,
  input  wire                                cfg_we_i,
  input  wire [rpva_pkg::LIMIT_W-1:0]        cfg_wdata_i
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned MAG_W = 2 * W + 4 - rpva_pkg::AREA_SHIFT;
  localparam int unsigned EXT_W = (MAG_W > 64) ? MAG_W : 64;

  logic en;
  logic [rpva_pkg::LIMIT_W-1:0] area_limit_q;

  rpva_pkg::beat_t  iss_beat, rot_beat, ar_beat, out_q;
  logic signed [W-1:0] iss_vx, iss_vy, iss_cx, iss_cy;
  logic signed [W-1:0] rot_x, rot_y, ar_x, ar_y;
  logic             rot_sat, ar_sat, ar_any;
  logic [MAG_W-1:0] ar_mag;

  logic [EXT_W-1:0]           mag_ext;
  logic                       area_sat;
  logic [rpva_pkg::AREA_W-1:0] area;
  logic                       last;

  logic signed [W-1:0]         ox_q, oy_q;
  logic [rpva_pkg::AREA_W-1:0] area_q;
  logic                        below_q, ovf_q;

  // Whole pipe advances unless a result beat is held
  assign en = !out_q.valid || out_ready_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_limit_q <= '0;
    end else if (cfg_we_i) begin
      area_limit_q <= cfg_wdata_i;
    end
  end

  rpva_issue #(.COORD_WIDTH(W)) u_issue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .vertex_x_i (vertex_x_i),
    .vertex_y_i (vertex_y_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .beat_o     (iss_beat),
    .vx_o       (iss_vx),
    .vy_o       (iss_vy),
    .cx_o       (iss_cx),
    .cy_o       (iss_cy)
  );

  rpva_rotate #(.COORD_WIDTH(W)) u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .beat_i (iss_beat),
    .vx_i   (iss_vx),
    .vy_i   (iss_vy),
    .cx_i   (iss_cx),
    .cy_i   (iss_cy),
    .beat_o (rot_beat),
    .x_o    (rot_x),
    .y_o    (rot_y),
    .sat_o  (rot_sat)
  );

  rpva_area #(.COORD_WIDTH(W)) u_area (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .beat_i (rot_beat),
    .x_i    (rot_x),
    .y_i    (rot_y),
    .sat_i  (rot_sat),
    .beat_o (ar_beat),
    .x_o    (ar_x),
    .y_o    (ar_y),
    .sat_o  (ar_sat),
    .any_o  (ar_any),
    .mag_o  (ar_mag)
  );

  // Area saturation and limit compare
  always_comb begin
    last     = (ar_beat.idx == rpva_pkg::LAST_IDX);
    mag_ext  = EXT_W'(ar_mag);
    area_sat = mag_ext > EXT_W'(rpva_pkg::AREA_MAX);
    area     = area_sat ? rpva_pkg::AREA_MAX : mag_ext[rpva_pkg::AREA_W-1:0];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en) begin
      out_q <= ar_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q    <= ar_x;
      oy_q    <= ar_y;
      area_q  <= last ? area : '0;
      below_q <= last && (area < {{(rpva_pkg::AREA_W - rpva_pkg::LIMIT_W - rpva_pkg::FRAC_W){1'b0}},
                                  area_limit_q, {rpva_pkg::FRAC_W{1'b0}}});
      ovf_q   <= last ? (ar_any || area_sat) : ar_sat;
    end
  end

  assign out_valid_o    = out_q.valid;
  assign vertex_index_o = out_q.idx;
  assign is_last_o      = (out_q.idx == rpva_pkg::LAST_IDX);
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign poly_area_o    = area_q;
  assign below_limit_o  = below_q;
  assign overflow_o     = ovf_q;

endmodule

`default_nettype wire

### tb/rpva_vertex_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the pentagon core, predicts the five vertex beats of every
// accepted pentagon and compares each result beat against the oldest prediction.
module rpva_vertex_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [31:0]            vertex_x_i,
  input  logic signed [31:0]            vertex_y_i,
  input  logic signed [31:0]            center_x_i,
  input  logic signed [31:0]            center_y_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [rpva_pkg::IDX_W-1:0]    vertex_index_i,
  input  logic [31:0]                   out_x_i,
  input  logic [31:0]                   out_y_i,
  input  logic                          is_last_i,
  input  logic [rpva_pkg::AREA_W-1:0]   poly_area_i,
  input  logic                          below_limit_i,
  input  logic                          overflow_i,
  input  logic                          cfg_we_i,
  input  logic [rpva_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  output int                            pending_o,
  output int                            mismatches_o,
  output int                            beats_o,
  output int                            below_o,
  output int                            overflow_o
);

  // cos / sin of 72k degrees in Q1.30, rounded to nearest
  localparam logic signed [31:0] COS72_Q30 [5] = '{
    32'sd1073741824, 32'sd331804471, -32'sd868675383, -32'sd868675383, 32'sd331804471
  };
  localparam logic signed [31:0] SIN72_Q30 [5] = '{
    32'sd0, 32'sd1021189159, 32'sd631129609, -32'sd631129609, -32'sd1021189159
  };
  localparam logic signed [127:0] ROUND_HALF = 128'sd536870912;
  localparam logic signed [127:0] COORD_TOP  = 128'sd2147483647;
  localparam logic signed [127:0] COORD_BOT  = -128'sd2147483648;
  localparam logic [127:0]        AREA_TOP   = 128'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    rpva_pkg::vidx_t              idx;
    logic [31:0]                  x;
    logic [31:0]                  y;
    logic                         last;
    logic [rpva_pkg::AREA_W-1:0]  area;
    logic                         below;
    logic                         ovf;
  } vertex_beat_t;

  vertex_beat_t                  expected_vertices [$];
  logic [rpva_pkg::LIMIT_W-1:0]  area_limit;

  function automatic logic signed [127:0] clamp_coord(input logic signed [127:0] v);
    if (v > COORD_TOP) return COORD_TOP;
    if (v < COORD_BOT) return COORD_BOT;
    return v;
  endfunction

  // Rotate the offset by -72k degrees, saturate, then take the shoelace area
  task automatic predict_pentagon(input logic signed [31:0] vx, input logic signed [31:0] vy,
                                  input logic signed [31:0] cx, input logic signed [31:0] cy);
    logic signed [127:0] dx, dy, rx, ry, raw_x, raw_y, acc;
    logic signed [127:0] xs [5];
    logic signed [127:0] ys [5];
    logic                sat [5];
    logic                any_sat, area_sat, below;
    logic [127:0]        mag;
    logic [63:0]         area, limit_q16;
    vertex_beat_t        beat;
    int                  k, n;
    dx = vx;
    dx = dx - cx;
    dy = vy;
    dy = dy - cy;
    xs[0] = vx;
    ys[0] = vy;
    sat[0] = 1'b0;
    any_sat = 1'b0;
    for (k = 1; k < 5; k++) begin
      rx = (dx * COS72_Q30[k] + dy * SIN72_Q30[k] + ROUND_HALF) >>> 30;
      ry = (dy * COS72_Q30[k] - dx * SIN72_Q30[k] + ROUND_HALF) >>> 30;
      raw_x = cx + rx;
      raw_y = cy + ry;
      xs[k] = clamp_coord(raw_x);
      ys[k] = clamp_coord(raw_y);
      sat[k] = (xs[k] != raw_x) || (ys[k] != raw_y);
      any_sat = any_sat | sat[k];
    end

    acc = '0;
    for (k = 0; k < 5; k++) begin
      n = (k + 1) % 5;
      acc = acc + xs[k] * ys[n] - xs[n] * ys[k];
    end
    if (acc < 0) acc = -acc;
    mag = acc >>> 17;  // halve, drop 16 fraction bits
    area_sat = (mag > AREA_TOP);
    area = area_sat ? AREA_TOP[63:0] : mag[63:0];
    limit_q16 = {33'b0, area_limit} << rpva_pkg::FRAC_W;
    below = (area < limit_q16);

    for (k = 0; k < 5; k++) begin
      beat.idx   = rpva_pkg::vidx_t'(k);
      beat.x     = xs[k][31:0];
      beat.y     = ys[k][31:0];
      beat.last  = (beat.idx == rpva_pkg::LAST_IDX);
      beat.area  = beat.last ? area[rpva_pkg::AREA_W-1:0] : '0;
      beat.below = beat.last && below;
      beat.ovf   = beat.last ? (any_sat || area_sat) : sat[k];
      expected_vertices = {expected_vertices, beat};
    end
  endtask

  task automatic check_field(input string name, input rpva_pkg::vidx_t idx,
                             input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: vertex %0d %s mismatch, expected %h actual %h",
               $time, idx, name, want, got);
      mismatches_o++;
    end
  endtask

  // Take the oldest prediction and compare the beat field by field
  task automatic check_vertex_beat();
    vertex_beat_t want;
    if (expected_vertices.size() == 0) begin
      $display("%0t: unexpected vertex beat, expected none, actual index %0d x %h y %h",
               $time, vertex_index_i, out_x_i, out_y_i);
      mismatches_o++;
    end else begin
      want = expected_vertices[0];
      expected_vertices.delete(0);
      check_field("vertex_index", want.idx, 64'(want.idx), 64'(vertex_index_i));
      check_field("out_x", want.idx, 64'(want.x), 64'(out_x_i));
      check_field("out_y", want.idx, 64'(want.y), 64'(out_y_i));
      check_field("is_last", want.idx, 64'(want.last), 64'(is_last_i));
      check_field("poly_area", want.idx, 64'(want.area), 64'(poly_area_i));
      check_field("below_limit", want.idx, 64'(want.below), 64'(below_limit_i));
      check_field("overflow", want.idx, 64'(want.ovf), 64'(overflow_i));
    end
    beats_o++;
    if (below_limit_i) below_o++;
    if (overflow_i) overflow_o++;
  endtask

  // Sample both channels and the config port at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_limit = '0;
    end else begin
      if (cfg_we_i) area_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        predict_pentagon(vertex_x_i, vertex_y_i, center_x_i, center_y_i);
      if (out_valid_i && out_ready_i) check_vertex_beat();
      pending_o = expected_vertices.size();
    end
  end

endmodule

### tb/tb_regular_pentagon_vertices_area_core.sv
`timescale 1ns / 100ps

module tb_regular_pentagon_vertices_area_core;

  localparam int CLK_HALF    = 6;
  localparam int PHASE_ITEMS = 58;
  localparam int N_PHASES    = 6;

  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE       = 32'sh0001_0000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          out_ready = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [rpva_pkg::LIMIT_W-1:0]  cfg_wdata = '0;
  logic signed [31:0]            vertex_x = '0;
  logic signed [31:0]            vertex_y = '0;
  logic signed [31:0]            center_x = '0;
  logic signed [31:0]            center_y = '0;

  logic                          in_ready;
  logic                          out_valid;
  logic [rpva_pkg::IDX_W-1:0]    vertex_index;
  logic signed [31:0]            out_x;
  logic signed [31:0]            out_y;
  logic                          is_last;
  logic [rpva_pkg::AREA_W-1:0]   poly_area;
  logic                          below_limit;
  logic                          overflow;

  int pending, mismatches, beats, below_hits, ovf_hits;
  int stall_left = 0;
  int pentagons_sent = 0;
  int limits_used = 1;  // reset value counts as the first setting
  logic steady = 1'b0;  // no idling on either side while set
  logic [rpva_pkg::LIMIT_W-1:0] limit_plan [N_PHASES];

  regular_pentagon_vertices_area_core #(
    .COORD_WIDTH(32)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .vertex_x_i     (vertex_x),
    .vertex_y_i     (vertex_y),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .vertex_index_o (vertex_index),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .is_last_o      (is_last),
    .poly_area_o    (poly_area),
    .below_limit_o  (below_limit),
    .overflow_o     (overflow),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  rpva_vertex_checker vertex_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .vertex_x_i     (vertex_x),
    .vertex_y_i     (vertex_y),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .vertex_index_i (vertex_index),
    .out_x_i        (out_x),
    .out_y_i        (out_y),
    .is_last_i      (is_last),
    .poly_area_i    (poly_area),
    .below_limit_i  (below_limit),
    .overflow_i     (overflow),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .pending_o      (pending),
    .mismatches_o   (mismatches),
    .beats_o        (beats),
    .below_o        (below_hits),
    .overflow_o     (ovf_hits)
  );

  // Clock
  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Result-side backpressure: mostly ready, short stalls, a few long ones
  always @(negedge clk) begin
    if (!rst_n || steady) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: stall_left = $urandom_range(0, 2);
        3:       stall_left = $urandom_range(15, 40);
        default: stall_left = -1;
      endcase
      out_ready <= (stall_left < 0);
      if (stall_left < 0) stall_left = 0;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one pentagon; called and returns at a falling edge, valid left high
  task automatic send_pentagon(input logic signed [31:0] vx, input logic signed [31:0] vy,
                               input logic signed [31:0] cx, input logic signed [31:0] cy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= vx;
    vertex_y <= vy;
    center_x <= cx;
    center_y <= cy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pentagons_sent++;
    @(negedge clk);
  endtask

  // Random pentagon: most often moderate sizes, plus full-range, rail-hugging,
  // tiny-offset and degenerate shapes
  task automatic send_random();
    logic signed [31:0] cx, cy, ox, oy;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      cx = $signed($urandom) >>> $urandom_range(4, 31);
      cy = $signed($urandom) >>> $urandom_range(4, 31);
      ox = $signed($urandom) >>> $urandom_range(6, 30);
      oy = $signed($urandom) >>> $urandom_range(6, 30);
    end else if (kind < 65) begin
      cx = $urandom;
      cy = $urandom;
      ox = $urandom;
      oy = $urandom;
    end else if (kind < 80) begin
      cx = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1 << 18)
                                : COORD_MIN + $urandom_range(0, 1 << 18);
      cy = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1 << 18)
                                : COORD_MIN + $urandom_range(0, 1 << 18);
      ox = $signed($urandom) >>> $urandom_range(10, 24);
      oy = $signed($urandom) >>> $urandom_range(10, 24);
    end else if (kind < 92) begin
      cx = $urandom;
      cy = $urandom;
      ox = $urandom_range(0, 6) - 3;
      oy = $urandom_range(0, 6) - 3;
    end else begin
      cx = $urandom;
      cy = $urandom;
      ox = '0;
      oy = '0;
    end
    send_pentagon(cx + ox, cy + oy, cx, cy);
  endtask

  // Hold off the sender until every predicted beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [rpva_pkg::LIMIT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limits_used++;
    @(negedge clk);
  endtask

  initial begin
    limit_plan[0] = 31'h7FFF_FFFF;
    limit_plan[1] = 31'd0;
    limit_plan[2] = 31'd1;
    limit_plan[3] = rpva_pkg::LIMIT_W'($urandom_range(1 << 10, 1 << 20));
    limit_plan[4] = rpva_pkg::LIMIT_W'($urandom);
    limit_plan[5] = 31'd32768;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: degenerate, unit and tiny offsets, rails and saturation
    send_pentagon(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_pentagon(ONE, 32'sd0, 32'sd0, 32'sd0);
    send_pentagon(32'sd0, ONE, 32'sd0, 32'sd0);
    send_pentagon(-ONE, -ONE, ONE, ONE);
    send_pentagon(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_pentagon(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_pentagon(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_pentagon(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_pentagon(COORD_MAX, COORD_MIN, 32'sd0, 32'sd0);
    send_pentagon(COORD_MIN, COORD_MAX, 32'sd0, 32'sd0);
    send_pentagon(COORD_MIN, 32'sd0, COORD_MAX, 32'sd0);
    send_pentagon(32'sd0, COORD_MAX, 32'sd0, COORD_MIN);
    send_pentagon(32'sd1, 32'sd0, 32'sd0, 32'sd0);
    send_pentagon(32'sd0, 32'sd1, 32'sd0, 32'sd0);
    send_pentagon(-32'sd1, -32'sd1, 32'sd0, 32'sd0);
    send_pentagon(32'sd3, -32'sd2, -32'sd1, 32'sd1);
    send_pentagon(COORD_MAX, 32'sd0, 32'sh7FFE_FFFF, 32'sd0);
    send_pentagon(COORD_MIN, 32'sd0, 32'sh8001_0000, 32'sd0);
    send_pentagon(ONE * 100, ONE * 50, -ONE * 20, ONE * 7);
    send_pentagon(32'sh4000_0000, 32'sd0, 32'sd0, 32'sd0);
    wait_drained();

    // Random phases, one area limit each; one phase runs without idling
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_drained();
      write_limit(limit_plan[phase]);
      steady = (phase == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random();
        if (phase == 3 && i == PHASE_ITEMS / 2) wait_drained();
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (30) @(negedge clk);

    $display("Covered %0d pentagons over %0d area limit settings, %0d vertex beats checked.",
             pentagons_sent, limits_used, beats);
    $display("Area below limit on %0d pentagons, saturation flagged on %0d beats.",
             below_hits, ovf_hits);
    if (mismatches == 0) begin
      $display("regular_pentagon_vertices_area_core regression: pass");
    end else begin
      $display("regular_pentagon_vertices_area_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(6_000_000);
    $display("Timeout with %0d vertex beats still outstanding", pending);
    $display("regular_pentagon_vertices_area_core regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/rpva_pkg.sv
rtl/rpva_issue.sv
rtl/rpva_rotate.sv
rtl/rpva_area.sv
rtl/regular_pentagon_vertices_area_core.sv
tb/rpva_vertex_checker.sv
tb/tb_regular_pentagon_vertices_area_core.sv
